>>> src/abba_pkg.sv
// Shared types and constants of the aligned bump block allocator.
`default_nettype none

package abba_pkg;

  // Width of the running byte count and its saturation value
  localparam int unsigned USED_W = 28;
  localparam logic [USED_W-1:0] USED_MAX = '1;

  // Block size used when the default register holds zero
  localparam int unsigned FALLBACK_SIZE = 4096;

  // Operation carried by an input word
  typedef enum logic [0:0] {
    OP_ALLOC  = 1'b0,
    OP_REWIND = 1'b1
  } opcode_e;

  // Controller states
  typedef enum logic [0:0] {
    ST_IDLE = 1'b0,
    ST_EXEC = 1'b1
  } ctrl_state_e;

  // Commands from controller to datapath
  typedef struct packed {
    logic capture;  // latch the input word and read the size table
    logic commit;   // update allocator state and load the result register
  } ctrl_cmd_t;

endpackage

`default_nettype wire

>>> src/abba_ctrl.sv
// Controller state machine: input acceptance, commit timing and result valid.
`default_nettype none

module abba_ctrl
  import abba_pkg::*;
(
  input  wire logic      clk_i,
  input  wire logic      rst_ni,
  input  wire logic      in_valid_i,
  output logic           in_stall_o,
  output logic           out_valid_o,
  input  wire logic      out_stall_i,
  output ctrl_cmd_t      cmd_o
);

  ctrl_state_e state_q, state_d;
  logic        out_valid_q, out_valid_d;

  // Next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (in_valid_i) state_d = ST_EXEC;
      end
      ST_EXEC: begin
        if (cmd_o.commit) state_d = ST_IDLE;
      end
    endcase
  end

  // Outputs: commit only once the result register is free or being emptied
  always_comb begin
    in_stall_o     = (state_q != ST_IDLE);
    cmd_o.capture  = (state_q == ST_IDLE) && in_valid_i;
    cmd_o.commit   = (state_q == ST_EXEC) && (!out_valid_q || !out_stall_i);
  end

  // Result valid flag: set on commit, drop when the word is taken
  always_comb begin
    out_valid_d = out_valid_q;
    if (cmd_o.commit) begin
      out_valid_d = 1'b1;
    end else if (!out_stall_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign out_valid_o = out_valid_q;

  // A held result is never overwritten by a commit
  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.commit |-> !(out_valid_q && out_stall_i))
    else $error("commit while result held");

  // Every commit presents a result on the next cycle
  a_commit_shows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.commit |=> out_valid_o)
    else $error("commit without result");

  // Capture and commit never coincide
  a_cap_commit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(cmd_o.capture && cmd_o.commit))
    else $error("capture and commit together");

endmodule

`default_nettype wire

>>> src/abba_datapath.sv
// Datapath: block size table, cursor, head, byte counts and result register.
`default_nettype none

module abba_datapath
  import abba_pkg::*;
#(
  parameter int unsigned MAX_BLOCKS = 16,
  parameter int unsigned SIZE_BITS  = 24
) (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire ctrl_cmd_t                     cmd_i,
  input  wire logic                          cfg_we_i,
  input  wire logic [SIZE_BITS-1:0]          default_block_size_i,
  input  wire logic                          opcode_i,
  input  wire logic [SIZE_BITS-1:0]          request_bytes_i,
  input  wire logic [3:0]                    align_log2_i,
  output logic [$clog2(MAX_BLOCKS)-1:0]      block_index_o,
  output logic [SIZE_BITS-1:0]               byte_offset_o,
  output logic                               block_appended_o,
  output logic [SIZE_BITS-1:0]               appended_size_o,
  output logic                               table_full_o,
  output logic [USED_W-1:0]                  bytes_used_o
);

  localparam int unsigned IDX_W = $clog2(MAX_BLOCKS);
  localparam int unsigned CNT_W = $clog2(MAX_BLOCKS + 1);
  // Aligned head may pass the block size by up to 2^15 - 1 before the fit check
  localparam int unsigned AL_W  = ((SIZE_BITS > 16) ? SIZE_BITS : 16) + 2;
  localparam int unsigned SUM_W = ((SIZE_BITS > USED_W) ? SIZE_BITS : USED_W) + 1;

  function automatic logic [USED_W-1:0] sat_used(input logic [SUM_W-1:0] v);
    return (v > SUM_W'(USED_MAX)) ? USED_MAX : v[USED_W-1:0];
  endfunction

  function automatic logic [SIZE_BITS-1:0] eff_default(input logic [SIZE_BITS-1:0] v);
    return (v == '0) ? SIZE_BITS'(FALLBACK_SIZE) : v;
  endfunction

  // Size table; entry zero lives in its own register
  logic [SIZE_BITS-1:0] blk_size_q [MAX_BLOCKS];
  logic [SIZE_BITS-1:0] rd_cur_q, rd_nxt_q;

  // Allocator state
  logic [SIZE_BITS-1:0] cfg_q, cfg_d;
  logic [SIZE_BITS-1:0] size0_q, size0_d;
  logic [CNT_W-1:0]     count_q, count_d;
  logic [IDX_W-1:0]     cur_q, cur_d;
  logic [SIZE_BITS-1:0] head_q, head_d;
  logic [USED_W-1:0]    used_q, used_d;
  logic [USED_W-1:0]    total_q, total_d;

  // Captured input word
  opcode_e              op_q;
  logic [SIZE_BITS-1:0] n_q;
  logic [AL_W-1:0]      aligned_q;

  // Result register inputs
  logic [IDX_W-1:0]     res_idx_d;
  logic [SIZE_BITS-1:0] res_off_d;
  logic                 res_app_d;
  logic [SIZE_BITS-1:0] res_asz_d;
  logic                 res_full_d;
  logic [USED_W-1:0]    res_used_d;

  logic [AL_W-1:0]      mask_w;
  logic [AL_W-1:0]      aligned_w;
  logic [SIZE_BITS-1:0] size_cur;
  logic [AL_W-1:0]      end_w;
  logic                 fits;
  logic                 can_move;
  logic                 can_append;
  logic [SIZE_BITS-1:0] dflt;
  logic [SIZE_BITS-1:0] app_size;
  logic [USED_W-1:0]    move_used;
  logic                 mem_we;

  // Round the head up to the requested alignment at capture
  always_comb begin
    mask_w    = (AL_W'(1) << align_log2_i) - AL_W'(1);
    aligned_w = (AL_W'(head_q) + mask_w) & ~mask_w;
  end

  // Capture the input word and read current and next block sizes
  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      op_q      <= opcode_e'(opcode_i);
      n_q       <= request_bytes_i;
      aligned_q <= aligned_w;
      rd_cur_q  <= blk_size_q[cur_q];
      rd_nxt_q  <= blk_size_q[cur_q + IDX_W'(1)];
    end
    if (mem_we) begin
      blk_size_q[count_q[IDX_W-1:0]] <= app_size;
    end
  end

  // Placement decisions
  always_comb begin
    size_cur   = (cur_q == '0) ? size0_q : rd_cur_q;
    end_w      = aligned_q + AL_W'(n_q);
    fits       = end_w <= AL_W'(size_cur);
    can_move   = ((CNT_W'(cur_q) + CNT_W'(1)) < count_q) && (n_q <= rd_nxt_q);
    can_append = count_q < CNT_W'(MAX_BLOCKS);
    dflt       = eff_default(cfg_q);
    app_size   = (n_q > dflt) ? n_q : dflt;
    move_used  = sat_used(SUM_W'(used_q) + SUM_W'(size_cur));
  end

  // Next state and result
  always_comb begin
    cfg_d      = cfg_q;
    size0_d    = size0_q;
    count_d    = count_q;
    cur_d      = cur_q;
    head_d     = head_q;
    used_d     = used_q;
    total_d    = total_q;
    mem_we     = 1'b0;
    res_idx_d  = cur_q;
    res_off_d  = '0;
    res_app_d  = 1'b0;
    res_asz_d  = '0;
    res_full_d = 1'b0;
    res_used_d = '0;

    // Register write; block zero follows it until the table grows
    if (cfg_we_i) begin
      cfg_d = default_block_size_i;
      if (count_q == CNT_W'(1)) begin
        size0_d = eff_default(default_block_size_i);
        total_d = sat_used(SUM_W'(eff_default(default_block_size_i)));
      end
    end

    if (cmd_i.commit) begin
      priority if (op_q == OP_REWIND) begin
        cur_d     = '0;
        head_d    = '0;
        used_d    = '0;
        res_idx_d = '0;
      end else if (fits) begin
        head_d     = end_w[SIZE_BITS-1:0];
        res_off_d  = aligned_q[SIZE_BITS-1:0];
        res_used_d = sat_used(SUM_W'(used_q) + SUM_W'(end_w[SIZE_BITS-1:0]));
      end else if (can_move) begin
        cur_d      = cur_q + IDX_W'(1);
        head_d     = n_q;
        used_d     = move_used;
        res_idx_d  = cur_q + IDX_W'(1);
        res_used_d = sat_used(SUM_W'(move_used) + SUM_W'(n_q));
      end else if (can_append) begin
        mem_we     = 1'b1;
        cur_d      = count_q[IDX_W-1:0];
        count_d    = count_q + CNT_W'(1);
        head_d     = n_q;
        used_d     = total_q;
        total_d    = sat_used(SUM_W'(total_q) + SUM_W'(app_size));
        res_idx_d  = count_q[IDX_W-1:0];
        res_app_d  = 1'b1;
        res_asz_d  = app_size;
        res_used_d = sat_used(SUM_W'(total_q) + SUM_W'(n_q));
      end else begin
        res_full_d = 1'b1;
        res_used_d = sat_used(SUM_W'(used_q) + SUM_W'(head_q));
      end
    end
  end

  // State registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q   <= SIZE_BITS'(FALLBACK_SIZE);
      size0_q <= SIZE_BITS'(FALLBACK_SIZE);
      count_q <= CNT_W'(1);
      cur_q   <= '0;
      head_q  <= '0;
      used_q  <= '0;
      total_q <= sat_used(SUM_W'(SIZE_BITS'(FALLBACK_SIZE)));
    end else begin
      cfg_q   <= cfg_d;
      size0_q <= size0_d;
      count_q <= count_d;
      cur_q   <= cur_d;
      head_q  <= head_d;
      used_q  <= used_d;
      total_q <= total_d;
    end
  end

  // Result register
  always_ff @(posedge clk_i) begin
    if (cmd_i.commit) begin
      block_index_o    <= res_idx_d;
      byte_offset_o    <= res_off_d;
      block_appended_o <= res_app_d;
      appended_size_o  <= res_asz_d;
      table_full_o     <= res_full_d;
      bytes_used_o     <= res_used_d;
    end
  end

  // Block count stays within the table
  a_count_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (count_q >= CNT_W'(1)) && (count_q <= CNT_W'(MAX_BLOCKS)))
    else $error("block count out of range");

  // Cursor always points at an existing block
  a_cur_exists: assert property (@(posedge clk_i) disable iff (!rst_ni)
    CNT_W'(cur_q) < count_q)
    else $error("cursor beyond last block");

  // A full table leaves the cursor where it was
  a_full_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_i.commit && (op_q == OP_ALLOC) && !fits && !can_move && !can_append)
      |=> $stable(cur_q) && $stable(count_q))
    else $error("state changed on full table");

endmodule

`default_nettype wire

>>> src/aligned_bump_block_allocator.sv
// Words: an accepted word is captured together with its registered block size reads,
//   then committed from EXEC into the result register once the result slot is free;
//   a new word is taken only after that commit, as in_stall_o is high in EXEC.
// A held result does not block the next word; its commit waits for the slot.
// Reset: one block of 4096 bytes, cursor, head and used byte count cleared; table entries
//   beyond block zero are written on append and need no clearing pass.
`default_nettype none

module aligned_bump_block_allocator
  import abba_pkg::*;
#(
  parameter int unsigned MAX_BLOCKS = 16,
  parameter int unsigned SIZE_BITS  = 24
) (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          cfg_we_i,
  input  wire logic [SIZE_BITS-1:0]          default_block_size_i,
  input  wire logic                          in_valid_i,
  output logic                               in_stall_o,
  input  wire logic                          opcode_i,
  input  wire logic [SIZE_BITS-1:0]          request_bytes_i,
  input  wire logic [3:0]                    align_log2_i,
  output logic                               out_valid_o,
  input  wire logic                          out_stall_i,
  output logic [$clog2(MAX_BLOCKS)-1:0]      block_index_o,
  output logic [SIZE_BITS-1:0]               byte_offset_o,
  output logic                               block_appended_o,
  output logic [SIZE_BITS-1:0]               appended_size_o,
  output logic                               table_full_o,
  output logic [USED_W-1:0]                  bytes_used_o
);

  ctrl_cmd_t cmd;

  // Sequencing
  abba_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .cmd_o       (cmd)
  );

  // Table, cursor and result
  abba_datapath #(
    .MAX_BLOCKS (MAX_BLOCKS),
    .SIZE_BITS  (SIZE_BITS)
  ) u_datapath (
    .clk_i                (clk_i),
    .rst_ni               (rst_ni),
    .cmd_i                (cmd),
    .cfg_we_i             (cfg_we_i),
    .default_block_size_i (default_block_size_i),
    .opcode_i             (opcode_i),
    .request_bytes_i      (request_bytes_i),
    .align_log2_i         (align_log2_i),
    .block_index_o        (block_index_o),
    .byte_offset_o        (byte_offset_o),
    .block_appended_o     (block_appended_o),
    .appended_size_o      (appended_size_o),
    .table_full_o         (table_full_o),
    .bytes_used_o         (bytes_used_o)
  );

endmodule

`default_nettype wire

>>> dv/tb_aligned_bump_block_allocator.sv
// Self-checking testbench for the aligned bump block allocator.
`default_nettype none

module tb_aligned_bump_block_allocator
  import abba_pkg::*;
();

  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned NUM_BLOCKS  = 16;
  localparam int unsigned SZ_W        = 24;
  localparam int unsigned HOLD_CYCLES = 40;
  localparam int unsigned STUCK_LIMIT = 1000;
  localparam logic [SZ_W-1:0] SZ_MAX  = '1;

  // One result word as the block reports it
  typedef struct packed {
    logic [3:0]        blk;
    logic [SZ_W-1:0]   off;
    logic              app;
    logic [SZ_W-1:0]   asz;
    logic              full;
    logic [USED_W-1:0] used;
  } alloc_result_t;

  // Tracks allocator state and the results still owed by the block
  class alloc_scoreboard;
    logic [SZ_W-1:0]  dflt_reg;
    logic [SZ_W-1:0]  blk_size [NUM_BLOCKS];
    int unsigned      n_blocks;
    int unsigned      cur_blk;
    longint unsigned  head;
    longint unsigned  base;
    longint unsigned  total;
    alloc_result_t    owed_q [$];
    int unsigned      fails;

    function new();
      foreach (blk_size[i]) blk_size[i] = '0;
      dflt_reg    = SZ_W'(FALLBACK_SIZE);
      blk_size[0] = dflt_reg;
      n_blocks    = 1;
      cur_blk     = 0;
      head        = 0;
      base        = 0;
      total       = FALLBACK_SIZE;
      fails       = 0;
    endfunction

    function longint unsigned eff_default();
      return (dflt_reg != '0) ? longint'(dflt_reg) : longint'(FALLBACK_SIZE);
    endfunction

    function longint unsigned clip_used(longint unsigned v);
      return (v > longint'(USED_MAX)) ? longint'(USED_MAX) : v;
    endfunction

    function int unsigned pending();
      return owed_q.size();
    endfunction

    // Bytes left in the current block behind the head
    function longint unsigned room_left();
      return (blk_size[cur_blk] >= head) ? blk_size[cur_blk] - head : 0;
    endfunction

    function longint unsigned next_size();
      return (cur_blk + 1 < n_blocks) ? longint'(blk_size[cur_blk + 1]) : eff_default();
    endfunction

    // Block zero follows the register until the first append
    function void write_default(logic [SZ_W-1:0] v);
      dflt_reg = v;
      if (n_blocks == 1) begin
        blk_size[0] = SZ_W'(eff_default());
        total       = eff_default();
      end
    endfunction

    // Advance the allocator by one accepted word and queue its result
    function void note_word(opcode_e op, logic [SZ_W-1:0] n, logic [3:0] al);
      alloc_result_t   r;
      longint unsigned mask;
      longint unsigned aligned;
      longint unsigned sz;
      r = '0;
      if (op == OP_REWIND) begin
        cur_blk = 0;
        head    = 0;
        base    = 0;
      end else begin
        mask    = (64'd1 << al) - 1;
        aligned = (head + mask) & ~mask;
        if (aligned + n <= blk_size[cur_blk]) begin
          head  = aligned + n;
          r.blk = 4'(cur_blk);
          r.off = SZ_W'(aligned);
        end else if (cur_blk + 1 < n_blocks && n <= blk_size[cur_blk + 1]) begin
          base    = clip_used(base + blk_size[cur_blk]);
          cur_blk = cur_blk + 1;
          head    = n;
          r.blk   = 4'(cur_blk);
        end else if (n_blocks < NUM_BLOCKS) begin
          // skipped blocks count as fully used: the base jumps to the total
          sz                 = (n > eff_default()) ? longint'(n) : eff_default();
          blk_size[n_blocks] = SZ_W'(sz);
          base               = clip_used(total);
          total              = clip_used(total + sz);
          cur_blk            = n_blocks;
          n_blocks           = n_blocks + 1;
          head               = n;
          r.blk              = 4'(cur_blk);
          r.app              = 1'b1;
          r.asz              = SZ_W'(sz);
        end else begin
          r.blk  = 4'(cur_blk);
          r.full = 1'b1;
        end
        r.used = USED_W'(clip_used(base + head));
      end
      owed_q.insert(owed_q.size(), r);
    endfunction

    function string fmt(alloc_result_t r);
      return $sformatf("blk=%0d off=%06h app=%0b asz=%06h full=%0b used=%07h",
                       r.blk, r.off, r.app, r.asz, r.full, r.used);
    endfunction

    // Compare one accepted result with the oldest owed one
    function void check(alloc_result_t got);
      alloc_result_t exp;
      if (owed_q.size() == 0) begin
        fails++;
        if (fails <= 10) $display("%0t: result with none owed: %s", $realtime, fmt(got));
        return;
      end
      exp = owed_q.pop_front();
      if (got.blk !== exp.blk || got.off !== exp.off || got.app !== exp.app ||
          got.asz !== exp.asz || got.full !== exp.full || got.used !== exp.used) begin
        fails++;
        if (fails <= 10)
          $display("%0t: mismatch\n  expected %s\n  actual   %s",
                   $realtime, fmt(exp), fmt(got));
      end
    endfunction
  endclass

  logic                clk_i;
  logic                rst_ni;
  logic                cfg_we_i;
  logic [SZ_W-1:0]     default_block_size_i;
  logic                in_valid_i;
  logic                in_stall_o;
  logic                opcode_i;
  logic [SZ_W-1:0]     request_bytes_i;
  logic [3:0]          align_log2_i;
  logic                out_valid_o;
  logic                out_stall_i;
  logic [3:0]          block_index_o;
  logic [SZ_W-1:0]     byte_offset_o;
  logic                block_appended_o;
  logic [SZ_W-1:0]     appended_size_o;
  logic                table_full_o;
  logic [USED_W-1:0]   bytes_used_o;

  alloc_scoreboard sb;
  logic            tx_idle_on;
  logic            rx_idle_on;
  logic            hold_req;
  int unsigned     stuck_cycles;

  aligned_bump_block_allocator #(
    .MAX_BLOCKS(NUM_BLOCKS),
    .SIZE_BITS (SZ_W)
  ) DUT (
    .clk_i               (clk_i),
    .rst_ni              (rst_ni),
    .cfg_we_i            (cfg_we_i),
    .default_block_size_i(default_block_size_i),
    .in_valid_i          (in_valid_i),
    .in_stall_o          (in_stall_o),
    .opcode_i            (opcode_i),
    .request_bytes_i     (request_bytes_i),
    .align_log2_i        (align_log2_i),
    .out_valid_o         (out_valid_o),
    .out_stall_i         (out_stall_i),
    .block_index_o       (block_index_o),
    .byte_offset_o       (byte_offset_o),
    .block_appended_o    (block_appended_o),
    .appended_size_o     (appended_size_o),
    .table_full_o        (table_full_o),
    .bytes_used_o        (bytes_used_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // Sample both channels and the register port; watch for a hung block
  always @(posedge clk_i) begin
    alloc_result_t got;
    if (rst_ni) begin
      if (cfg_we_i) sb.write_default(default_block_size_i);
      if (in_valid_i && !in_stall_o)
        sb.note_word(opcode_e'(opcode_i), request_bytes_i, align_log2_i);
      if (out_valid_o && !out_stall_i) begin
        got = '{blk: block_index_o, off: byte_offset_o, app: block_appended_o,
                asz: appended_size_o, full: table_full_o, used: bytes_used_o};
        sb.check(got);
      end
      if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i))
        stuck_cycles = 0;
      else
        stuck_cycles = stuck_cycles + 1;
      if (stuck_cycles >= STUCK_LIMIT) begin
        $display("status: fail");
        $finish;
      end
    end
  end

  // Drive the result stall: a long hold on request, else random bursts
  initial begin
    forever begin
      if (hold_req) begin
        out_stall_i = 1'b1;
        repeat (HOLD_CYCLES) @(negedge clk_i);
        hold_req = 1'b0;
      end else if (rx_idle_on && $urandom_range(0, 4) == 0) begin
        out_stall_i = 1'b1;
        repeat ($urandom_range(1, 4)) @(negedge clk_i);
      end else begin
        out_stall_i = 1'b0;
        @(negedge clk_i);
      end
    end
  end

  // Offer one word, with an optional gap first, and hold it until taken
  task automatic send_word(opcode_e op, logic [SZ_W-1:0] n, logic [3:0] al);
    if (tx_idle_on && $urandom_range(0, 3) == 0) begin
      in_valid_i = 1'b0;
      repeat ($urandom_range(1, 4)) @(negedge clk_i);
    end
    in_valid_i      = 1'b1;
    opcode_i        = op;
    request_bytes_i = n;
    align_log2_i    = al;
    do @(posedge clk_i); while (in_stall_o);
    @(negedge clk_i);
  endtask

  // Drop valid and wait for every owed result
  task automatic drain();
    in_valid_i = 1'b0;
    while (sb.pending() != 0) @(negedge clk_i);
  endtask

  // Write the register once the block has gone idle
  task automatic write_reg(logic [SZ_W-1:0] v);
    drain();
    repeat (3) @(negedge clk_i);
    cfg_we_i             = 1'b1;
    default_block_size_i = v;
    @(negedge clk_i);
    cfg_we_i = 1'b0;
  endtask

  // Pick a size near a boundary of interest
  function automatic logic [SZ_W-1:0] near(longint unsigned centre);
    longint v;
    v = longint'(centre) + longint'($urandom_range(0, 2)) - 1;
    if (v < 0) v = 0;
    if (v > longint'(SZ_MAX)) v = longint'(SZ_MAX);
    return SZ_W'(v);
  endfunction

  // Mostly well-formed allocations aimed at fit and move edges
  task automatic send_random(int unsigned count, int unsigned hold_at, int unsigned pause_at);
    int unsigned     pick;
    logic [SZ_W-1:0] n;
    logic [3:0]      al;
    for (int unsigned k = 0; k < count; k++) begin
      if (k == hold_at) hold_req = 1'b1;
      if (k == pause_at) drain();
      pick = $urandom_range(0, 99);
      al   = ($urandom_range(0, 9) < 7) ? 4'($urandom_range(0, 3)) : 4'($urandom_range(0, 15));
      if (pick < 8)       send_word(OP_REWIND, SZ_W'($urandom()), 4'($urandom()));
      else begin
        if (pick < 35)      n = SZ_W'($urandom_range(0, 255));
        else if (pick < 55) n = SZ_W'($urandom_range(0, 8191));
        else if (pick < 75) n = near(sb.room_left());
        else if (pick < 90) n = near(sb.next_size());
        else                n = SZ_W'($urandom());
        send_word(OP_ALLOC, n, al);
      end
    end
  endtask

  initial begin
    sb                   = new();
    rst_ni               = 1'b0;
    cfg_we_i             = 1'b0;
    default_block_size_i = '0;
    in_valid_i           = 1'b0;
    opcode_i             = OP_ALLOC;
    request_bytes_i      = '0;
    align_log2_i         = '0;
    out_stall_i          = 1'b0;
    tx_idle_on           = 1'b1;
    rx_idle_on           = 1'b1;
    hold_req             = 1'b0;
    stuck_cycles         = 0;
    repeat (6) @(negedge clk_i);
    rst_ni = 1'b1;

    // Zero falls back to 4096, then a one-byte block zero
    write_reg('0);
    write_reg(24'd1);
    send_word(OP_ALLOC, 24'd0, 4'd0);
    send_word(OP_ALLOC, 24'd1, 4'd15);
    send_word(OP_ALLOC, 24'd0, 4'd1);
    send_word(OP_REWIND, 24'd0, 4'd0);
    send_word(OP_ALLOC, 24'd1, 4'd0);
    send_word(OP_ALLOC, 24'd1, 4'd0);
    send_word(OP_ALLOC, 24'd5, 4'd0);

    // Largest default and request; alignment past the head
    write_reg(SZ_MAX);
    send_word(OP_ALLOC, SZ_MAX, 4'd0);
    send_word(OP_ALLOC, 24'd3, 4'd12);
    send_word(OP_ALLOC, 24'd4, 4'd15);
    send_word(OP_REWIND, SZ_MAX, 4'hF);

    // Append past skipped blocks until the table is full, then overflow it
    write_reg('0);
    for (int unsigned i = 0; i < 12; i++)
      send_word(OP_ALLOC, SZ_W'(2500 + 1000 * i), 4'(i));
    send_word(OP_ALLOC, SZ_MAX, 4'd0);

    write_reg(SZ_W'($urandom_range(1, 2 ** SZ_W - 1)));
    send_random(300, 0, 0);
    write_reg(SZ_W'($urandom()));
    send_random(300, 50, 150);
    write_reg(24'd1);
    send_random(200, 0, 0);

    // Final stretch at full rate on both sides, no hold and no pause
    write_reg('0);
    tx_idle_on = 1'b0;
    rx_idle_on = 1'b0;
    send_random(225, 225, 225);

    drain();
    repeat (5) @(negedge clk_i);
    if (sb.pending() != 0) sb.fails++;
    if (sb.fails == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule

`default_nettype wire
